[hdl/ssl_pkg.sv]
`default_nettype none

package ssl_pkg;

  localparam int MAX_SERVOS = 8;
  localparam int IDX_W      = 3;
  localparam int CNT_W      = 4;
  localparam int DEG_W      = 8;
  localparam int ANG_W      = 13;
  localparam int STEP_W     = 8;
  localparam int PACK_W     = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int UPC_W      = 3;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DEG_W-1:0]  deg_t;
  typedef logic [ANG_W-1:0]  ang_t;
  typedef logic [STEP_W-1:0] step_t;
  typedef logic [PACK_W-1:0] pack_t;
  typedef logic [UPC_W-1:0]  upc_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SERVO_COUNT    = 3'd0,
    CFG_HAND_FIRST     = 3'd1,
    CFG_ARM_STEP       = 3'd2,
    CFG_HAND_STEP      = 3'd3,
    CFG_MIN_ANGLES     = 3'd4,
    CFG_MAX_ANGLES     = 3'd5,
    CFG_INITIAL_ANGLES = 3'd6
  } cfg_reg_t;

  localparam cnt_t  RST_SERVO_COUNT = 4'd8;
  localparam cnt_t  RST_HAND_FIRST  = 4'd4;
  localparam step_t RST_ARM_STEP    = 8'd16;
  localparam step_t RST_HAND_STEP   = 8'd16;
  localparam pack_t RST_MIN_ANGLES  = 64'h0;
  localparam pack_t RST_MAX_ANGLES  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam pack_t RST_INIT_ANGLES = 64'h5A5A_5A5A_5A5A_5A5A;
  localparam deg_t  RST_TARGET      = 8'd90;
  localparam ang_t  RST_CURRENT     = 13'd1456;
  localparam ang_t  ANG_LIMIT       = 13'd4096;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SET     = 2'd1,
    OP_BIAS    = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_NOP     = 3'd0,
    ACT_SET     = 3'd1,
    ACT_BIAS    = 3'd2,
    ACT_RESTART = 3'd3,
    ACT_TICK    = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    SEQ_DISPATCH   = 2'd0,
    SEQ_JUMP       = 2'd1,
    SEQ_SKIP_EMPTY = 2'd2,
    SEQ_LOOP       = 2'd3
  } seq_t;

  localparam upc_t UPC_IDLE      = 3'd0;
  localparam upc_t UPC_SET       = 3'd1;
  localparam upc_t UPC_BIAS      = 3'd2;
  localparam upc_t UPC_RESTART   = 3'd3;
  localparam upc_t UPC_TICK_INIT = 3'd4;
  localparam upc_t UPC_TICK_STEP = 3'd5;

  typedef struct packed {
    action_t action;
    seq_t    seq;
    logic    lim_all;
    upc_t    target;
  } uword_t;

  typedef struct packed {
    action_t action;
    logic    lim_all;
    logic    accept;
  } dp_ctrl_t;

  typedef struct packed {
    logic more;
    logic empty;
  } dp_stat_t;

  function automatic uword_t ucode_rom(input upc_t a);
    uword_t w;
    case (a)
      UPC_IDLE:      w = '{ACT_NOP,     SEQ_DISPATCH,   1'b0, UPC_IDLE};
      UPC_SET:       w = '{ACT_SET,     SEQ_JUMP,       1'b0, UPC_IDLE};
      UPC_BIAS:      w = '{ACT_BIAS,    SEQ_JUMP,       1'b0, UPC_IDLE};
      UPC_RESTART:   w = '{ACT_RESTART, SEQ_LOOP,       1'b1, UPC_RESTART};
      UPC_TICK_INIT: w = '{ACT_NOP,     SEQ_SKIP_EMPTY, 1'b0, UPC_IDLE};
      UPC_TICK_STEP: w = '{ACT_TICK,    SEQ_LOOP,       1'b0, UPC_TICK_STEP};
      default:       w = '{ACT_NOP,     SEQ_JUMP,       1'b0, UPC_IDLE};
    endcase
    return w;
  endfunction

  function automatic upc_t dispatch(input op_t op);
    upc_t a;
    case (op)
      OP_TICK:    a = UPC_TICK_INIT;
      OP_SET:     a = UPC_SET;
      OP_BIAS:    a = UPC_BIAS;
      OP_RESTART: a = UPC_RESTART;
      default:    a = UPC_IDLE;
    endcase
    return a;
  endfunction

  function automatic deg_t get_byte(input pack_t w, input idx_t i);
    return w[{i, 3'b000} +: DEG_W];
  endfunction

  function automatic deg_t clamp_angle(input logic signed [DEG_W+1:0] v,
                                       input deg_t lo, input deg_t hi);
    deg_t r;
    if (v < $signed({2'b00, lo})) begin
      r = lo;
    end else if (v > $signed({2'b00, hi})) begin
      r = hi;
    end else begin
      r = v[DEG_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/servo_slew_limiter.sv]
`default_nettype none

// channel  | ports                                              | handshake
// input    | in_operation in_servo_index in_target_angle ...    | start & !busy
// result   | out_servo_number out_current_angle out_last        | out_valid strobe
// config   | cfg_index cfg_data                                 | cfg_valid & cfg_ready
//
// restart does one servo per step for all servos, not only active ones; tick runs an init
// step, then one per active servo (at most 8); the loop index visits one servo per cycle
// results appear in the cycle after their step, one per cycle, last marked
// synchronous active-low reset loads register defaults, targets 90 and angles 1456
// cfg_ready is always high; the result side cannot stall

module servo_slew_limiter (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_operation,
  input  wire logic [2:0]        in_servo_index,
  input  wire logic [7:0]        in_target_angle,
  input  wire logic signed [7:0] in_bias_angle,
  output logic                   out_valid,
  output logic [2:0]             out_servo_number,
  output logic [12:0]            out_current_angle,
  output logic                   out_last,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [63:0]       cfg_data
);

  ssl_pkg::dp_ctrl_t ctrl;
  ssl_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  ssl_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_operation),
    .stat      (stat),
    .busy      (busy),
    .ctrl      (ctrl)
  );

  ssl_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .stat              (stat),
    .servo_index       (in_servo_index),
    .target_angle      (in_target_angle),
    .bias_angle        (in_bias_angle),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_servo_number  (out_servo_number),
    .out_current_angle (out_current_angle),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

[hdl/ssl_seq.sv]
`default_nettype none

module ssl_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [1:0]        operation,
  input  wire ssl_pkg::dp_stat_t stat,
  output logic                   busy,
  output ssl_pkg::dp_ctrl_t      ctrl
);

  ssl_pkg::upc_t   upc_r;
  ssl_pkg::upc_t   upc_nxt;
  ssl_pkg::uword_t word;

  assign word = ssl_pkg::ucode_rom(upc_r);
  assign busy = (upc_r != ssl_pkg::UPC_IDLE);

  always_comb begin
    ctrl.action  = word.action;
    ctrl.lim_all = word.lim_all;
    ctrl.accept  = start && (upc_r == ssl_pkg::UPC_IDLE);
  end

  always_comb begin
    case (word.seq)
      ssl_pkg::SEQ_DISPATCH:
        upc_nxt = start ? ssl_pkg::dispatch(ssl_pkg::op_t'(operation)) : upc_r;
      ssl_pkg::SEQ_JUMP:
        upc_nxt = word.target;
      ssl_pkg::SEQ_SKIP_EMPTY:
        upc_nxt = stat.empty ? ssl_pkg::UPC_IDLE : upc_r + ssl_pkg::upc_t'(1);
      ssl_pkg::SEQ_LOOP:
        upc_nxt = stat.more ? word.target : ssl_pkg::UPC_IDLE;
      default:
        upc_nxt = ssl_pkg::UPC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ssl_pkg::UPC_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/ssl_dp.sv]
`default_nettype none

module ssl_dp (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ssl_pkg::dp_ctrl_t     ctrl,
  output ssl_pkg::dp_stat_t          stat,
  input  wire logic [2:0]            servo_index,
  input  wire logic [7:0]            target_angle,
  input  wire logic signed [7:0]     bias_angle,
  input  wire logic                  cfg_valid,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [63:0]           cfg_data,
  output logic                       out_valid,
  output logic [2:0]                 out_servo_number,
  output logic [12:0]                out_current_angle,
  output logic                       out_last
);

  ssl_pkg::cnt_t  servo_count_r;
  ssl_pkg::cnt_t  hand_first_r;
  ssl_pkg::step_t arm_step_r;
  ssl_pkg::step_t hand_step_r;
  ssl_pkg::pack_t min_angles_r;
  ssl_pkg::pack_t max_angles_r;
  ssl_pkg::pack_t init_angles_r;

  ssl_pkg::deg_t  target_r  [ssl_pkg::MAX_SERVOS];
  ssl_pkg::ang_t  current_r [ssl_pkg::MAX_SERVOS];

  ssl_pkg::idx_t  idx_r;
  ssl_pkg::idx_t  lat_idx_r;
  ssl_pkg::deg_t  lat_tgt_r;
  logic signed [7:0] lat_bias_r;

  logic           out_valid_r;
  ssl_pkg::idx_t  out_num_r;
  ssl_pkg::ang_t  out_ang_r;
  logic           out_last_r;

  ssl_pkg::cnt_t  active_n;
  ssl_pkg::cnt_t  idx_p1;
  logic           lat_in_range;
  logic signed [ssl_pkg::DEG_W+1:0] bias_sum;
  ssl_pkg::deg_t  lo_byte;
  ssl_pkg::deg_t  hi_byte;
  ssl_pkg::deg_t  init_byte;
  ssl_pkg::step_t step;
  ssl_pkg::ang_t  goal;
  ssl_pkg::ang_t  cur;
  ssl_pkg::ang_t  gap;
  ssl_pkg::ang_t  step_w;
  ssl_pkg::ang_t  cur_nxt;

  logic           tgt_we;
  ssl_pkg::idx_t  tgt_wa;
  ssl_pkg::deg_t  tgt_wd;
  logic           cur_we;
  ssl_pkg::ang_t  cur_wd;

  assign active_n = (servo_count_r > ssl_pkg::cnt_t'(ssl_pkg::MAX_SERVOS)) ?
                    ssl_pkg::cnt_t'(ssl_pkg::MAX_SERVOS) : servo_count_r;
  assign idx_p1   = {1'b0, idx_r} + ssl_pkg::cnt_t'(1);

  always_comb begin
    stat.empty = (active_n == '0);
    stat.more  = ctrl.lim_all ? (idx_p1 < ssl_pkg::cnt_t'(ssl_pkg::MAX_SERVOS))
                              : (idx_p1 < active_n);
  end

  // set and bias path
  assign lat_in_range = ({1'b0, lat_idx_r} < active_n);
  assign lo_byte      = ssl_pkg::get_byte(min_angles_r, lat_idx_r);
  assign hi_byte      = ssl_pkg::get_byte(max_angles_r, lat_idx_r);
  assign bias_sum     = $signed({2'b00, target_r[lat_idx_r]})
                      + $signed({{2{lat_bias_r[7]}}, lat_bias_r});
  assign init_byte    = ssl_pkg::get_byte(init_angles_r, idx_r);

  // tick path
  assign step    = ({1'b0, idx_r} < hand_first_r) ? arm_step_r : hand_step_r;
  assign step_w  = {5'b0, step};
  assign goal    = {1'b0, target_r[idx_r], 4'b0000};
  assign cur     = current_r[idx_r];
  assign gap     = (cur > goal) ? (cur - goal) : (goal - cur);
  assign cur_nxt = (gap >= step_w) ? ((goal > cur) ? (cur + step_w) : (cur - step_w)) : goal;

  always_comb begin
    tgt_we = 1'b0;
    tgt_wa = lat_idx_r;
    tgt_wd = lat_tgt_r;
    cur_we = 1'b0;
    cur_wd = cur_nxt;
    case (ctrl.action)
      ssl_pkg::ACT_SET: begin
        tgt_we = lat_in_range;
        tgt_wd = ssl_pkg::clamp_angle($signed({2'b00, lat_tgt_r}), lo_byte, hi_byte);
      end
      ssl_pkg::ACT_BIAS: begin
        tgt_we = lat_in_range;
        tgt_wd = ssl_pkg::clamp_angle(bias_sum, lo_byte, hi_byte);
      end
      ssl_pkg::ACT_RESTART: begin
        tgt_we = 1'b1;
        tgt_wa = idx_r;
        tgt_wd = init_byte;
        cur_we = 1'b1;
        cur_wd = {({1'b0, init_byte} + 9'd1), 4'b0000};
      end
      ssl_pkg::ACT_TICK: begin
        cur_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo_count_r <= ssl_pkg::RST_SERVO_COUNT;
      hand_first_r  <= ssl_pkg::RST_HAND_FIRST;
      arm_step_r    <= ssl_pkg::RST_ARM_STEP;
      hand_step_r   <= ssl_pkg::RST_HAND_STEP;
      min_angles_r  <= ssl_pkg::RST_MIN_ANGLES;
      max_angles_r  <= ssl_pkg::RST_MAX_ANGLES;
      init_angles_r <= ssl_pkg::RST_INIT_ANGLES;
    end else if (cfg_valid) begin
      case (ssl_pkg::cfg_reg_t'(cfg_index))
        ssl_pkg::CFG_SERVO_COUNT:    servo_count_r <= cfg_data[3:0];
        ssl_pkg::CFG_HAND_FIRST:     hand_first_r  <= cfg_data[3:0];
        ssl_pkg::CFG_ARM_STEP:       arm_step_r    <= cfg_data[7:0];
        ssl_pkg::CFG_HAND_STEP:      hand_step_r   <= cfg_data[7:0];
        ssl_pkg::CFG_MIN_ANGLES:     min_angles_r  <= cfg_data;
        ssl_pkg::CFG_MAX_ANGLES:     max_angles_r  <= cfg_data;
        ssl_pkg::CFG_INITIAL_ANGLES: init_angles_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ssl_pkg::MAX_SERVOS; i++) begin
        target_r[i]  <= ssl_pkg::RST_TARGET;
        current_r[i] <= ssl_pkg::RST_CURRENT;
      end
    end else begin
      if (tgt_we) begin
        target_r[tgt_wa] <= tgt_wd;
      end
      if (cur_we) begin
        current_r[idx_r] <= cur_wd;
      end
    end
  end

  // loop index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (ctrl.accept) begin
      idx_r <= '0;
    end else if (ctrl.action == ssl_pkg::ACT_RESTART || ctrl.action == ssl_pkg::ACT_TICK) begin
      idx_r <= idx_r + ssl_pkg::idx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      lat_idx_r  <= servo_index;
      lat_tgt_r  <= target_angle;
      lat_bias_r <= bias_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (ctrl.action == ssl_pkg::ACT_TICK);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.action == ssl_pkg::ACT_TICK) begin
      out_num_r  <= idx_r;
      out_ang_r  <= cur_nxt;
      out_last_r <= !stat.more;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_servo_number  = out_num_r;
  assign out_current_angle = out_ang_r;
  assign out_last          = out_last_r;

  // checks
  a_valid_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(ctrl.action == ssl_pkg::ACT_TICK))
    else $error("result without tick step");

  a_last_ends_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> !out_valid_r)
    else $error("result right after last");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ang_r <= ssl_pkg::ANG_LIMIT))
    else $error("angle out of range");

  a_number_in_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, out_num_r} < active_n))
    else $error("servo number beyond count");

endmodule

`default_nettype wire
